/* rtl/sfra_pkg.sv */
// ----------------------------------------------------------------------------
// sfra_pkg
// shared sizes, command and status types of the sorted free-run slot allocator
// ----------------------------------------------------------------------------
package sfra_pkg;

   localparam int unsigned POOL_SLOTS  = 4096;
   localparam int unsigned SLOT_W      = $clog2(POOL_SLOTS);
   localparam int unsigned END_W       = $clog2(POOL_SLOTS + 1);
   localparam int unsigned IDX_W       = 12;
   localparam int unsigned CNT_W       = 12;
   localparam int unsigned REQ_TDATA_W = 16;
   localparam int unsigned RSP_TDATA_W = 32;

   typedef struct packed {
      logic clr_step;
      logic accept;
      logic alloc_upd;
      logic free_chk;
      logic walk_rend;
      logic walk_link;
      logic fin;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic bad;
      logic front;
      logic walk_more;
      logic rsp_free;
   } sts_type;

endpackage

/* rtl/sfra_dp.sv */
// ----------------------------------------------------------------------------
// sfra_dp
// slot tables, list registers, run walk datapath and result register
// ----------------------------------------------------------------------------
module sfra_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [sfra_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sfra_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  sfra_pkg::cmd_type                   cmd,
   output sfra_pkg::sts_type                   sts
);
   import sfra_pkg::*;

   // slot tables
   logic              use_mem  [POOL_SLOTS];
   logic [SLOT_W-1:0] link_mem [POOL_SLOTS];
   logic [END_W-1:0]  rend_mem [POOL_SLOTS];

   logic              use_q0_ff;
   logic              use_q1_ff;
   logic [SLOT_W-1:0] link_q_ff;
   logic [END_W-1:0]  rend_q_ff;

   logic [SLOT_W-1:0] clr_addr_ff;
   logic [SLOT_W-1:0] free_head_ff;
   logic [SLOT_W-1:0] used_ff;
   logic              func_ff;
   logic [IDX_W-1:0]  fidx_ff;
   logic [SLOT_W-1:0] head_ff;
   logic [SLOT_W-1:0] last_ff;
   logic [END_W-1:0]  after_ff;
   logic [SLOT_W-1:0] res_gnt_ff;
   logic              res_full_ff;
   logic              res_bad_ff;
   logic              rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;

   logic [SLOT_W-1:0] req_slot;
   logic [SLOT_W-1:0] req_nx;
   logic [SLOT_W-1:0] fidx_slot;
   logic [END_W-1:0]  fidx_nx;
   logic              nx_in_pool;
   logic [END_W-1:0]  after_calc;
   logic              bad;
   logic              front;
   logic [SLOT_W-1:0] last_calc;
   logic              walk_more;
   logic              head_nz;
   logic              run_goes_on;
   logic              adjacent;

   logic              use_we;
   logic [SLOT_W-1:0] use_wa;
   logic              use_wd;
   logic [SLOT_W-1:0] use_ra0;
   logic [SLOT_W-1:0] use_ra1;
   logic              link_we;
   logic [SLOT_W-1:0] link_wa;
   logic [SLOT_W-1:0] link_wd;
   logic [SLOT_W-1:0] link_ra;
   logic              rend_we;
   logic [SLOT_W-1:0] rend_wa;
   logic [END_W-1:0]  rend_wd;
   logic [SLOT_W-1:0] rend_ra;

   assign req_slot    = SLOT_W'(req_tdata[IDX_W-1:0]);
   assign req_nx      = req_slot + SLOT_W'(1);
   assign fidx_slot   = SLOT_W'(fidx_ff);
   assign fidx_nx     = END_W'(fidx_slot) + END_W'(1);
   assign nx_in_pool  = fidx_nx < END_W'(POOL_SLOTS);
   assign after_calc  = (nx_in_pool && !use_q1_ff) ? rend_q_ff : fidx_nx;
   assign bad         = (fidx_ff == '0) || (32'(fidx_ff) >= POOL_SLOTS) || !use_q0_ff;
   assign front       = (free_head_ff == '0) || (fidx_slot < free_head_ff);
   assign last_calc   = (rend_q_ff == '0) ? '0 : SLOT_W'(rend_q_ff - END_W'(1));
   assign walk_more   = (link_q_ff != '0) && (link_q_ff < fidx_slot);
   assign head_nz     = free_head_ff != '0;
   assign run_goes_on = (link_q_ff != '0) && (link_q_ff == free_head_ff + SLOT_W'(1));
   assign adjacent    = fidx_slot == last_ff + SLOT_W'(1);

   // table port selection
   always_comb begin
      use_we  = 1'b0;
      use_wa  = fidx_slot;
      use_wd  = 1'b0;
      link_we = 1'b0;
      link_wa = fidx_slot;
      link_wd = free_head_ff;
      rend_we = 1'b0;
      rend_wa = fidx_slot;
      rend_wd = after_calc;
      use_ra0 = req_slot;
      use_ra1 = req_nx;
      link_ra = cmd.walk_rend ? last_calc : free_head_ff;
      priority if (cmd.free_chk) begin
         rend_ra = free_head_ff;
      end else if (cmd.walk_link) begin
         rend_ra = link_q_ff;
      end else begin
         rend_ra = req_tuser ? req_nx : free_head_ff;
      end

      priority if (cmd.clr_step) begin
         use_we  = 1'b1;
         use_wa  = clr_addr_ff;
         link_we = 1'b1;
         link_wa = clr_addr_ff;
         link_wd = ((clr_addr_ff == '0) || (clr_addr_ff == SLOT_W'(POOL_SLOTS - 1))) ?
                   '0 : clr_addr_ff + SLOT_W'(1);
         rend_we = 1'b1;
         rend_wa = clr_addr_ff;
         rend_wd = (clr_addr_ff == SLOT_W'(1)) ? END_W'(POOL_SLOTS) : '0;
      end else if (cmd.alloc_upd) begin
         use_we  = head_nz;
         use_wa  = free_head_ff;
         use_wd  = 1'b1;
         rend_we = head_nz && run_goes_on;
         rend_wa = link_q_ff;
         rend_wd = rend_q_ff;
      end else if (cmd.free_chk) begin
         use_we  = !bad;
         link_we = !bad && front;
         rend_we = !bad && front;
      end else if (cmd.walk_link) begin
         link_we = !walk_more;
         link_wd = link_q_ff;
         rend_we = !walk_more;
         rend_wd = after_ff;
      end else if (cmd.fin) begin
         link_we = 1'b1;
         link_wa = last_ff;
         link_wd = fidx_slot;
         rend_we = adjacent;
         rend_wa = head_ff;
         rend_wd = after_ff;
      end else begin
         use_we  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (use_we) begin
         use_mem[use_wa] <= use_wd;
      end
      use_q0_ff <= use_mem[use_ra0];
      use_q1_ff <= use_mem[use_ra1];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_q_ff <= link_mem[link_ra];
   end

   always_ff @(posedge clock) begin
      if (rend_we) begin
         rend_mem[rend_wa] <= rend_wd;
      end
      rend_q_ff <= rend_mem[rend_ra];
   end

   // list and count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff   <= '0;
         free_head_ff  <= SLOT_W'(1);
         used_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + SLOT_W'(1);
         end
         if (cmd.alloc_upd && head_nz) begin
            free_head_ff <= link_q_ff;
            used_ff      <= used_ff + SLOT_W'(1);
         end
         if (cmd.free_chk && !bad) begin
            used_ff <= used_ff - SLOT_W'(1);
            if (front) begin
               free_head_ff <= fidx_slot;
            end
         end
         if (cmd.load_rsp) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // item payload and walk registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff     <= req_tuser;
         fidx_ff     <= req_tdata[IDX_W-1:0];
         res_gnt_ff  <= '0;
         res_full_ff <= 1'b0;
         res_bad_ff  <= 1'b0;
      end
      if (cmd.alloc_upd) begin
         res_gnt_ff  <= free_head_ff;
         res_full_ff <= !head_nz;
      end
      if (cmd.free_chk) begin
         res_bad_ff <= bad && func_ff;
         after_ff   <= after_calc;
         head_ff    <= free_head_ff;
      end
      if (cmd.walk_rend) begin
         last_ff <= last_calc;
      end
      if (cmd.walk_link && walk_more) begin
         head_ff <= link_q_ff;
      end
      if (cmd.load_rsp) begin
         rsp_tdata_ff <= RSP_TDATA_W'({CNT_W'(used_ff), res_bad_ff, res_full_ff,
                                       IDX_W'(res_gnt_ff)});
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign sts.clr_done  = clr_addr_ff == SLOT_W'(POOL_SLOTS - 1);
   assign sts.bad       = bad;
   assign sts.front     = front;
   assign sts.walk_more = walk_more;
   assign sts.rsp_free  = !rsp_tvalid_ff || rsp_tready;

endmodule

/* rtl/sfra_ctrl.sv */
// ----------------------------------------------------------------------------
// sfra_ctrl
// sequencer for clearing, allocate, free check, run walk and result hand-off
// ----------------------------------------------------------------------------
module sfra_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_tuser,
   input  sfra_pkg::sts_type sts,
   output sfra_pkg::cmd_type cmd
);
   import sfra_pkg::*;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_ALLOC = 8'b0000_0100,
      S_FCHK  = 8'b0000_1000,
      S_WRUN  = 8'b0001_0000,
      S_WLINK = 8'b0010_0000,
      S_FIN   = 8'b0100_0000,
      S_RESP  = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.accept = req_tvalid;
            if (req_tvalid) begin
               state_in = req_tuser ? S_FCHK : S_ALLOC;
            end
         end
         S_ALLOC: begin
            cmd.alloc_upd = 1'b1;
            state_in      = S_RESP;
         end
         S_FCHK: begin
            cmd.free_chk = 1'b1;
            state_in     = (sts.bad || sts.front) ? S_RESP : S_WRUN;
         end
         S_WRUN: begin
            cmd.walk_rend = 1'b1;
            state_in      = S_WLINK;
         end
         S_WLINK: begin
            cmd.walk_link = 1'b1;
            state_in      = sts.walk_more ? S_WRUN : S_FIN;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            cmd.load_rsp = sts.rsp_free;
            if (sts.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;

endmodule

/* rtl/sorted_free_run_slot_allocator.sv */
// ----------------------------------------------------------------------------
// sorted_free_run_slot_allocator
// slot allocator over a fixed pool with an index-ordered list of free runs
// ----------------------------------------------------------------------------
// After reset the block sweeps its slot tables once, one slot a cycle, and
// holds req_tready low until all POOL_SLOTS slots are cleared. Each request
// word then gives one response word. An allocate passes the allocate state
// and then the response state, which loads the response register once it is
// free. A free does the same when it is refused or when the slot lands ahead
// of the list head; otherwise it walks the free runs in index order, with one
// read of the run-end table and then one of the link table per run passed,
// each a registered read, then links the slot in before the response loads.
// The controller is back in idle as the response loads, ready for a request.
// A new request is taken while the previous response still waits on rsp_tready.
module sorted_free_run_slot_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // free_index[11:0], zero pad
   input  logic [sfra_pkg::REQ_TDATA_W-1:0] req_tdata,
   // func (0 allocate, 1 free)
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // granted_index[11:0], pool_full[12], bad_free[13], allocated_count[25:14]
   output logic [sfra_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import sfra_pkg::*;

   cmd_type cmd;
   sts_type sts;

   sfra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   sfra_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

/* rtl/sfra_checker.sv */
// ----------------------------------------------------------------------------
// sfra_checker
// port-level checks of the slot allocator, bound to the top level
// ----------------------------------------------------------------------------
module sfra_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [sfra_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [sfra_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import sfra_pkg::*;

   // table sweep follows every reset
   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response word changed");

   a_full_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12] |->
         rsp_tdata[11:0] == '0 && !rsp_tdata[13]
         && rsp_tdata[25:14] == CNT_W'(POOL_SLOTS - 1))
      else $error("pool full word inconsistent");

   a_bad_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[13] |-> rsp_tdata[11:0] == '0)
      else $error("refused free carries a granted slot");

endmodule

bind sorted_free_run_slot_allocator sfra_checker u_sfra_checker (.*);

/* sim/sfra_tb_pkg.sv */
// ----------------------------------------------------------------------------
// sfra_tb_pkg
// request codes and the response word layout shared by the allocator testbench
// ----------------------------------------------------------------------------
package sfra_tb_pkg;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // low bits first: granted, full, bad, count
   typedef struct packed {
      logic [sfra_pkg::CNT_W-1:0] count;
      logic                       bad;
      logic                       full;
      logic [sfra_pkg::IDX_W-1:0] granted;
   } slot_reply_type;

   localparam int unsigned REPLY_W = $bits(slot_reply_type);

endpackage

/* sim/slot_grant_checker.sv */
// ----------------------------------------------------------------------------
// slot_grant_checker
// Watches the request and response streams of the slot allocator. Each
// accepted request word is run through a local copy of the free-run tables
// to work out its response; each accepted response word is compared field by
// field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module slot_grant_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [sfra_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [sfra_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int unsigned                      mismatches,
   output int unsigned                      awaiting
);
   import sfra_pkg::*;
   import sfra_tb_pkg::*;

   bit                in_use   [POOL_SLOTS];
   logic [SLOT_W-1:0] link     [POOL_SLOTS];
   logic [END_W-1:0]  run_end  [POOL_SLOTS];
   logic [SLOT_W-1:0] head;
   logic [CNT_W-1:0]  used;

   slot_reply_type replies_due[$];

   function automatic int unsigned in_pool(input int unsigned x);
      return (x < POOL_SLOTS) ? x : 0;
   endfunction

   function automatic void clear_pool();
      for (int unsigned i = 0; i < POOL_SLOTS; i++) begin
         in_use[i]  = 1'b0;
         run_end[i] = '0;
         link[i]    = (i + 1 < POOL_SLOTS) ? SLOT_W'(i + 1) : '0;
      end
      link[0]    = '0;
      run_end[1] = END_W'(POOL_SLOTS);
      head       = SLOT_W'(1);
      used       = '0;
   endfunction

   function automatic logic [SLOT_W-1:0] take_lowest();
      int unsigned at;
      int unsigned nxt;
      at  = in_pool(32'(head));
      nxt = in_pool(32'(link[at]));
      // the run continues, so its end moves to the new head
      if (nxt != 0 && nxt == at + 1) run_end[nxt] = run_end[at];
      used       = used + CNT_W'(1);
      head       = nxt[SLOT_W-1:0];
      in_use[at] = 1'b1;
      return at[SLOT_W-1:0];
   endfunction

   function automatic void return_slot(input int unsigned idx);
      int unsigned after;
      int unsigned run_head;
      int unsigned run_last;
      int unsigned follow;
      int unsigned guard;
      used        = used - CNT_W'(1);
      in_use[idx] = 1'b0;
      after       = idx + 1;
      if (after < POOL_SLOTS && !in_use[after]) after = 32'(run_end[after]);
      if (head == 0 || idx < 32'(head)) begin
         link[idx]    = head;
         run_end[idx] = after[END_W-1:0];
         head         = idx[SLOT_W-1:0];
         return;
      end
      follow   = 32'(head);
      run_head = 0;
      run_last = 0;
      guard    = 0;
      // walk one run per step until the next run starts above the slot
      do begin
         run_head = in_pool(follow);
         run_last = 32'(run_end[run_head]);
         run_last = (run_last == 0) ? 0 : in_pool(run_last - 1);
         follow   = in_pool(32'(link[run_last]));
         guard++;
      end while (follow != 0 && follow < idx && guard < POOL_SLOTS);
      link[idx]      = follow[SLOT_W-1:0];
      run_end[idx]   = after[END_W-1:0];
      link[run_last] = idx[SLOT_W-1:0];
      if (idx == run_last + 1) run_end[run_head] = after[END_W-1:0];
   endfunction

   function automatic slot_reply_type predict_reply(input logic func,
                                                    input logic [IDX_W-1:0] slot);
      slot_reply_type r;
      r = '0;
      if (func == OP_ALLOC) begin
         if (head == 0) r.full = 1'b1;
         else r.granted = take_lowest();
      end else if (slot == 0 || 32'(slot) >= POOL_SLOTS || !in_use[slot]) begin
         r.bad = 1'b1;
      end else begin
         return_slot(32'(slot));
      end
      r.count = used;
      return r;
   endfunction

   task automatic flag(input string field, input int unsigned want_v,
                       input int unsigned got_v);
      $display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
      mismatches++;
   endtask

   always @(posedge clock) begin
      slot_reply_type want;
      slot_reply_type got;
      if (reset) begin
         clear_pool();
         replies_due.delete();
         mismatches = 0;
      end else begin
         if (req_tvalid && req_tready)
            replies_due.push_back(predict_reply(req_tuser, req_tdata[IDX_W-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[REPLY_W-1:0];
            if (replies_due.size() == 0) begin
               $display("%0t: response word expected none actual %h", $time, got);
               mismatches++;
            end else begin
               want = replies_due.pop_front();
               if (got.granted !== want.granted)
                  flag("granted_index", 32'(want.granted), 32'(got.granted));
               if (got.full !== want.full)
                  flag("pool_full", 32'(want.full), 32'(got.full));
               if (got.bad !== want.bad)
                  flag("bad_free", 32'(want.bad), 32'(got.bad));
               if (got.count !== want.count)
                  flag("allocated_count", 32'(want.count), 32'(got.count));
            end
         end
      end
      awaiting = replies_due.size();
   end

endmodule

/* sim/tb_sorted_free_run_slot_allocator.sv */
// ----------------------------------------------------------------------------
// tb_sorted_free_run_slot_allocator
// Drives allocate and free words into the slot allocator: a directed opening
// over run joins and refused frees, random churn under three idling mixes, a
// long fill and a scattered release across the filled part of the pool. The
// checker beside the block predicts every response word.
// ----------------------------------------------------------------------------
module tb_sorted_free_run_slot_allocator;
   import sfra_pkg::*;
   import sfra_tb_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int unsigned mismatches;
   int unsigned awaiting;
   int unsigned req_gap_pct;
   int unsigned rsp_stall_pct;
   int unsigned live_slots[$];

   sorted_free_run_slot_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   slot_grant_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .awaiting   (awaiting)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   // granted slots become candidates for freeing
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready && rsp_tdata[IDX_W-1:0] != '0)
         live_slots.push_back(32'(rsp_tdata[IDX_W-1:0]));
   end

   task automatic push_word(input logic func, input logic [IDX_W-1:0] slot);
      logic [REQ_TDATA_W-1:0] word;
      word              = '0;
      word[IDX_W-1:0]   = slot;
      req_tvalid       <= 1'b1;
      req_tuser        <= func;
      req_tdata        <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      while ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic alloc_word();
      push_word(OP_ALLOC, IDX_W'($urandom_range(4095)));
   endtask

   task automatic free_word(input int unsigned slot);
      int hits[$];
      hits = live_slots.find_first_index(s) with (s == slot);
      if (hits.size() != 0) live_slots.delete(hits[0]);
      push_word(OP_FREE, IDX_W'(slot));
   endtask

   task automatic free_live_word();
      free_word(live_slots[$urandom_range(live_slots.size() - 1)]);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
   endtask

   task automatic churn(input int unsigned items, input int unsigned gap_pct,
                        input int unsigned stall_pct);
      int unsigned target;
      int unsigned roll;
      int unsigned alloc_pct;
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      target        = $urandom_range(120, 1);
      for (int unsigned n = 0; n < items; n++) begin
         if (n % 160 == 159) target = $urandom_range(120, 1);
         alloc_pct = (live_slots.size() < target) ? 60 : 30;
         roll      = $urandom_range(99);
         if (live_slots.size() == 0 || roll < alloc_pct) alloc_word();
         else if (roll < 92) free_live_word();
         else if (roll < 98) free_word($urandom_range(4095));
         else free_word($urandom_range(1) ? 4095 : 0);
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tuser     = OP_ALLOC;
      req_tdata     = '0;
      req_gap_pct   = 38;
      rsp_stall_pct = 75;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // refused frees, front inserts and joins from both sides
      repeat (6) alloc_word();
      free_word(0);
      free_word(4095);
      free_word(3);
      free_word(3);
      free_word(5);
      free_word(4);
      free_word(6);
      repeat (6) alloc_word();
      free_word(2);
      free_word(7);
      free_word(5);
      free_word(6);
      free_word(1);
      repeat (2) alloc_word();
      settle();

      churn(450, 38, 75);
      settle();
      churn(450, 75, 38);
      settle();
      churn(450, 0, 0);
      settle();

      // fill a long stretch of the pool, then scatter the free runs across it
      repeat (400) alloc_word();
      settle();
      free_word(4095);
      free_word(1);
      free_word(2048);
      repeat (60) free_live_word();
      repeat (40) alloc_word();
      repeat (30) free_live_word();
      repeat (40) alloc_word();
      settle();
      repeat (64) @(posedge clock);

      if (mismatches == 0 && awaiting == 0)
         $display("sorted_free_run_slot_allocator regression: pass");
      else
         $display("sorted_free_run_slot_allocator regression: fail");
      $finish;
   end

   initial begin
      #40000000;
      $display("sorted_free_run_slot_allocator regression: fail");
      $finish;
   end

endmodule
